>>> rtl/bscr_pkg.sv
// shared types and constants of the block storage card register block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package bscr_pkg;

    localparam int BYTE_W      = 8;
    localparam int REG_OFS_W   = 4;
    localparam int BLOCK_NUM_W = 16;
    localparam int CFG_UNITS   = 2;
    localparam int PRES_W      = 2;
    localparam int COUNT_W     = 7;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int CFG_IDX_W   = 3;

    // access direction
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // device register offsets
    localparam logic [REG_OFS_W-1:0] OFS_SELECT   = 4'd0;
    localparam logic [REG_OFS_W-1:0] OFS_BLOCK_LO = 4'd1;
    localparam logic [REG_OFS_W-1:0] OFS_BLOCK_HI = 4'd2;
    localparam logic [REG_OFS_W-1:0] OFS_DATA     = 4'd3;
    localparam logic [REG_OFS_W-1:0] OFS_STATUS   = 4'd4;

    // presence codes
    localparam logic [PRES_W-1:0] PRES_ABSENT = 2'd0;
    localparam logic [PRES_W-1:0] PRES_LOADED = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // returned bytes
    localparam logic [BYTE_W-1:0] BYTE_FAIL        = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_NO_MEDIUM = 8'h80;
    localparam logic [BYTE_W-1:0] STATUS_LOCKED    = 8'h40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRES0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROT1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT1 = 3'd5;

    typedef struct packed {
        logic [CFG_UNITS-1:0][PRES_W-1:0]  presence;
        logic [CFG_UNITS-1:0]              protect;
        logic [CFG_UNITS-1:0][COUNT_W-1:0] count;
    } cfg_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } med_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADDR,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_PRIME,
        ST_PRIME_LAST,
        ST_STAGE,
        ST_COMMIT,
        ST_COMMIT_LAST,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/bscr_if.sv
// valid/ready channels for bus requests and their read responses
// depends on bscr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bscr_req_if;
    import bscr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [REG_OFS_W-1:0] reg_offset;
    logic [BYTE_W-1:0]    write_data;

    modport source (output valid, kind, reg_offset, write_data, input ready);
    modport sink   (input valid, kind, reg_offset, write_data, output ready);
endinterface

interface bscr_rsp_if;
    import bscr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

`default_nettype wire

>>> rtl/block_storage_card_registers_top.sv
// Block storage card register block. Bus requests are taken one at a time; a new request
// is accepted while the previous read byte still waits in the response register. A request
// is decoded and then answered; a data read of a valid block first reads one medium byte.
// The first staged byte of a block first fills the block buffer from the medium, and the
// byte that wraps the offset of a valid block then writes the buffer back; both copies move
// one byte a cycle through the single medium port. After reset the medium is cleared one
// byte a cycle, all UNITS * MAX_BLOCKS * BLOCK_BYTES bytes (65536 with the defaults), during
// which no request is accepted; configuration writes are taken at all times.
// depends on bscr_pkg, bscr_if, bscr_cfg_regs, bscr_medium, bscr_ctrl
`timescale 1ns / 1ps
`default_nettype none

module block_storage_card_registers_top #(
    parameter int UNITS       = 2,
    parameter int BLOCK_BYTES = 512,
    parameter int MAX_BLOCKS  = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bscr_req_if.sink                    req,
    bscr_rsp_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bscr_pkg::APB_AW-1:0] paddr,
    input  logic [bscr_pkg::APB_DW-1:0] pwdata,
    output logic [bscr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import bscr_pkg::*;

    localparam int MED_DEPTH = UNITS * MAX_BLOCKS * BLOCK_BYTES;
    localparam int MED_AW    = $clog2(MED_DEPTH);

    cfg_t              cfg;
    med_ctl_t          med_ctl;
    logic [MED_AW-1:0] med_addr;
    logic [BYTE_W-1:0] med_wdata;
    logic [BYTE_W-1:0] med_rdata;
    logic              med_ready;

    bscr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bscr_medium #(
        .DEPTH (MED_DEPTH),
        .AW    (MED_AW)
    ) u_medium (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (med_ctl),
        .addr  (med_addr),
        .wdata (med_wdata),
        .rdata (med_rdata),
        .ready (med_ready)
    );

    bscr_ctrl #(
        .UNITS       (UNITS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS),
        .MED_AW      (MED_AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .med_ready (med_ready),
        .med_ctl   (med_ctl),
        .med_addr  (med_addr),
        .med_wdata (med_wdata),
        .med_rdata (med_rdata)
    );

endmodule

`default_nettype wire

>>> rtl/bscr_cfg_regs.sv
// apb configuration registers: presence, protect and block count of units 0 and 1
// depends on bscr_pkg
`timescale 1ns / 1ps
`default_nettype none

module bscr_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bscr_pkg::APB_AW-1:0]    paddr,
    input  logic [bscr_pkg::APB_DW-1:0]    pwdata,
    output logic [bscr_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,
    output bscr_pkg::cfg_t                 cfg
);
    import bscr_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [CFG_IDX_W-1:0] idx;

    assign idx    = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (idx)
                CFG_PRES0:  cfg_next.presence[0] = pwdata[PRES_W-1:0];
                CFG_PRES1:  cfg_next.presence[1] = pwdata[PRES_W-1:0];
                CFG_PROT0:  cfg_next.protect[0]  = pwdata[0];
                CFG_PROT1:  cfg_next.protect[1]  = pwdata[0];
                CFG_COUNT0: cfg_next.count[0]    = pwdata[COUNT_W-1:0];
                CFG_COUNT1: cfg_next.count[1]    = pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (idx)
            CFG_PRES0:  prdata[PRES_W-1:0]  = cfg_reg.presence[0];
            CFG_PRES1:  prdata[PRES_W-1:0]  = cfg_reg.presence[1];
            CFG_PROT0:  prdata[0]           = cfg_reg.protect[0];
            CFG_PROT1:  prdata[0]           = cfg_reg.protect[1];
            CFG_COUNT0: prdata[COUNT_W-1:0] = cfg_reg.count[0];
            CFG_COUNT1: prdata[COUNT_W-1:0] = cfg_reg.count[1];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.presence <= {CFG_UNITS{PRES_ABSENT}};
            cfg_reg.protect  <= '0;
            cfg_reg.count    <= {CFG_UNITS{COUNT_RESET}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/bscr_medium.sv
// medium storage: single-port byte memory with registered read and a clearing sweep after reset
// depends on bscr_pkg
`timescale 1ns / 1ps
`default_nettype none

module bscr_medium #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bscr_pkg::med_ctl_t          ctl,
    input  logic [AW-1:0]               addr,
    input  logic [bscr_pkg::BYTE_W-1:0] wdata,
    output logic [bscr_pkg::BYTE_W-1:0] rdata,
    output logic                        ready
);
    import bscr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic              clearing_reg;
    logic              clearing_next;
    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     clr_addr_next;

    assign ready = !clearing_reg;
    assign rdata = rdata_reg;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bscr_ctrl.sv
// request sequencer: unit state, block buffer memory, prime and commit copies, response register
// depends on bscr_pkg and bscr_if; drives the medium memory port
`timescale 1ns / 1ps
`default_nettype none

module bscr_ctrl #(
    parameter int UNITS       = 2,
    parameter int BLOCK_BYTES = 512,
    parameter int MAX_BLOCKS  = 64,
    parameter int MED_AW      = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bscr_req_if.sink                    req,
    bscr_rsp_if.source                  rsp,
    input  bscr_pkg::cfg_t              cfg,
    input  logic                        med_ready,
    output bscr_pkg::med_ctl_t          med_ctl,
    output logic [MED_AW-1:0]           med_addr,
    output logic [bscr_pkg::BYTE_W-1:0] med_wdata,
    input  logic [bscr_pkg::BYTE_W-1:0] med_rdata
);
    import bscr_pkg::*;

    localparam int UNIT_W    = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int OFS_W     = $clog2(BLOCK_BYTES);
    localparam int BUF_DEPTH = UNITS * BLOCK_BYTES;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int ROWS      = UNITS * MAX_BLOCKS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LUT_N     = 1 << BYTE_W;

    localparam logic [OFS_W-1:0]       OFS_LAST     = OFS_W'(BLOCK_BYTES - 1);
    localparam logic [BLOCK_NUM_W:0]   MAX_BLOCKS_V = (BLOCK_NUM_W + 1)'(MAX_BLOCKS);

    // byte value to unit number, modulo the unit count
    function automatic logic [LUT_N*UNIT_W-1:0] build_unit_lut();
        logic [LUT_N*UNIT_W-1:0] lut;
        int                      r;
        lut = '0;
        r   = 0;
        for (int i = 0; i < LUT_N; i++)
        begin
            lut[i*UNIT_W +: UNIT_W] = UNIT_W'(r);
            r = (r == UNITS - 1) ? 0 : r + 1;
        end
        return lut;
    endfunction

    localparam logic [LUT_N*UNIT_W-1:0] UNIT_LUT = build_unit_lut();

    // per-unit view of configuration
    logic [PRES_W-1:0]  unit_pres  [UNITS];
    logic               unit_prot  [UNITS];
    logic [COUNT_W-1:0] unit_count [UNITS];

    for (genvar g = 0; g < UNITS; g++)
    begin : g_unit_cfg
        if (g < CFG_UNITS)
        begin : g_reg
            assign unit_pres[g]  = cfg.presence[g];
            assign unit_prot[g]  = cfg.protect[g];
            assign unit_count[g] = cfg.count[g];
        end
        else
        begin : g_fixed
            assign unit_pres[g]  = PRES_ABSENT;
            assign unit_prot[g]  = 1'b0;
            assign unit_count[g] = COUNT_RESET;
        end
    end

    state_t                 state_reg;
    state_t                 state_next;
    logic [UNIT_W-1:0]      active_reg;
    logic [UNIT_W-1:0]      active_next;
    logic [BLOCK_NUM_W-1:0] blk_reg     [UNITS];
    logic [BLOCK_NUM_W-1:0] blk_next    [UNITS];
    logic [OFS_W-1:0]       sofs_reg    [UNITS];
    logic [OFS_W-1:0]       sofs_next   [UNITS];
    logic                   primed_reg  [UNITS];
    logic                   primed_next [UNITS];
    logic                   pend_reg;
    logic                   pend_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;

    logic                   kind_reg;
    logic [REG_OFS_W-1:0]   roff_reg;
    logic [BYTE_W-1:0]      wdata_reg;
    logic                   ok_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [BUF_AW-1:0]      bbase_reg;
    logic [MED_AW-1:0]      mbase_reg;
    logic [OFS_W-1:0]       cnt_reg;
    logic [OFS_W-1:0]       cnt_next;
    logic [OFS_W-1:0]       cnt_d_reg;
    logic [OFS_W-1:0]       cnt_d_next;
    logic [BYTE_W-1:0]      res_reg;
    logic [BYTE_W-1:0]      res_next;
    logic [BYTE_W-1:0]      out_data_reg;
    logic [BYTE_W-1:0]      out_data_next;

    // block buffer memory
    logic [BYTE_W-1:0]      wbuf_mem [BUF_DEPTH];
    logic [BYTE_W-1:0]      wbuf_rdata_reg;
    logic                   wbuf_we;
    logic [BUF_AW-1:0]      wbuf_waddr;
    logic [BYTE_W-1:0]      wbuf_wdata;
    logic                   wbuf_re;
    logic [BUF_AW-1:0]      wbuf_raddr;

    logic [BLOCK_NUM_W-1:0] cur_blk;
    logic [OFS_W-1:0]       cur_ofs;
    logic [OFS_W-1:0]       ofs_inc;
    logic [PRES_W-1:0]      cur_pres;
    logic                   cur_prot;
    logic                   cur_loaded;
    logic                   cur_ok;
    logic [BYTE_W-1:0]      status_byte;
    logic [UNIT_W-1:0]      new_unit;
    logic                   accept;

    assign cur_blk    = blk_reg[active_reg];
    assign cur_ofs    = sofs_reg[active_reg];
    assign cur_pres   = unit_pres[active_reg];
    assign cur_prot   = unit_prot[active_reg];
    assign cur_loaded = (cur_pres == PRES_LOADED);
    assign cur_ok     = ({1'b0, cur_blk} < MAX_BLOCKS_V)
                        && (cur_blk < BLOCK_NUM_W'(unit_count[active_reg]));
    assign ofs_inc    = (cur_ofs == OFS_LAST) ? '0 : cur_ofs + 1'b1;
    assign new_unit   = UNIT_LUT[wdata_reg*UNIT_W +: UNIT_W];

    assign status_byte = (cur_loaded ? '0 : STATUS_NO_MEDIUM)
                         | (((cur_pres == PRES_ABSENT) || cur_prot) ? STATUS_LOCKED : '0);

    assign req.ready     = (state_reg == ST_IDLE) && med_ready;
    assign accept        = req.valid && req.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        blk_next       = blk_reg;
        sofs_next      = sofs_reg;
        primed_next    = primed_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        cnt_d_next     = cnt_d_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        med_ctl        = '0;
        med_addr       = '0;
        med_wdata      = '0;
        wbuf_we        = 1'b0;
        wbuf_waddr     = '0;
        wbuf_wdata     = '0;
        wbuf_re        = 1'b0;
        wbuf_raddr     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                state_next = ST_DONE;
                if (kind_reg == KIND_READ)
                begin
                    res_next = BYTE_FAIL;
                    case (roff_reg)
                        OFS_DATA:
                        begin
                            if (cur_loaded && cur_ok)
                            begin
                                state_next = ST_ADDR;
                            end
                        end
                        OFS_STATUS: res_next = status_byte;
                        default: ;
                    endcase
                end
                else
                begin
                    res_next = '0;
                    case (roff_reg)
                        OFS_SELECT:
                        begin
                            active_next         = new_unit;
                            sofs_next[new_unit] = '0;
                        end
                        OFS_BLOCK_LO:
                        begin
                            blk_next[active_reg][BYTE_W-1:0] = wdata_reg;
                            sofs_next[active_reg]             = '0;
                            primed_next[active_reg]           = 1'b0;
                        end
                        OFS_BLOCK_HI:
                        begin
                            blk_next[active_reg][BLOCK_NUM_W-1:BYTE_W] = wdata_reg;
                            sofs_next[active_reg]                       = '0;
                            primed_next[active_reg]                     = 1'b0;
                        end
                        OFS_DATA:
                        begin
                            if (cur_loaded && !cur_prot)
                            begin
                                state_next = ST_ADDR;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_ADDR:
            begin
                pend_next = 1'b0;
                cnt_next  = '0;
                if (kind_reg == KIND_READ)
                begin
                    state_next = ST_RD_ISSUE;
                end
                else if ((cur_ofs == '0) && !primed_reg[active_reg])
                begin
                    state_next = ST_PRIME;
                end
                else
                begin
                    state_next = ST_STAGE;
                end
            end

            ST_RD_ISSUE:
            begin
                med_ctl.rd = 1'b1;
                med_addr   = mbase_reg + MED_AW'(cur_ofs);
                state_next = ST_RD_WAIT;
            end

            ST_RD_WAIT:
            begin
                res_next              = med_rdata;
                sofs_next[active_reg] = ofs_inc;
                state_next            = ST_DONE;
            end

            ST_PRIME:
            begin
                med_ctl.rd = ok_reg;
                med_addr   = mbase_reg + MED_AW'(cnt_reg);
                if (pend_reg)
                begin
                    wbuf_we    = 1'b1;
                    wbuf_waddr = bbase_reg + BUF_AW'(cnt_d_reg);
                    wbuf_wdata = ok_reg ? med_rdata : '0;
                end
                pend_next  = 1'b1;
                cnt_d_next = cnt_reg;
                if (cnt_reg == OFS_LAST)
                begin
                    state_next = ST_PRIME_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_PRIME_LAST:
            begin
                wbuf_we                 = 1'b1;
                wbuf_waddr              = bbase_reg + BUF_AW'(cnt_d_reg);
                wbuf_wdata              = ok_reg ? med_rdata : '0;
                pend_next               = 1'b0;
                primed_next[active_reg] = 1'b1;
                state_next              = ST_STAGE;
            end

            ST_STAGE:
            begin
                wbuf_we               = 1'b1;
                wbuf_waddr            = bbase_reg + BUF_AW'(cur_ofs);
                wbuf_wdata            = wdata_reg;
                sofs_next[active_reg] = ofs_inc;
                pend_next             = 1'b0;
                cnt_next              = '0;
                state_next            = ST_DONE;
                // offset wraps: write the block back if it is valid
                if (cur_ofs == OFS_LAST)
                begin
                    if (ok_reg)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        primed_next[active_reg] = 1'b0;
                    end
                end
            end

            ST_COMMIT:
            begin
                wbuf_re    = 1'b1;
                wbuf_raddr = bbase_reg + BUF_AW'(cnt_reg);
                if (pend_reg)
                begin
                    med_ctl.wr = 1'b1;
                    med_addr   = mbase_reg + MED_AW'(cnt_d_reg);
                    med_wdata  = wbuf_rdata_reg;
                end
                pend_next  = 1'b1;
                cnt_d_next = cnt_reg;
                if (cnt_reg == OFS_LAST)
                begin
                    state_next = ST_COMMIT_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_COMMIT_LAST:
            begin
                med_ctl.wr              = 1'b1;
                med_addr                = mbase_reg + MED_AW'(cnt_d_reg);
                med_wdata               = wbuf_rdata_reg;
                pend_next               = 1'b0;
                primed_next[active_reg] = 1'b0;
                state_next              = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            blk_reg       <= '{default: '0};
            sofs_reg      <= '{default: '0};
            primed_reg    <= '{default: 1'b0};
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            blk_reg       <= blk_next;
            sofs_reg      <= sofs_next;
            primed_reg    <= primed_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= req.kind;
            roff_reg  <= req.reg_offset;
            wdata_reg <= req.write_data;
        end
        if (state_reg == ST_DECODE)
        begin
            ok_reg    <= cur_ok;
            row_reg   <= ROW_W'(32'(active_reg) * 32'(MAX_BLOCKS) + 32'(cur_blk));
            bbase_reg <= BUF_AW'(32'(active_reg) * 32'(BLOCK_BYTES));
        end
        if (state_reg == ST_ADDR)
        begin
            mbase_reg <= MED_AW'(32'(row_reg) * 32'(BLOCK_BYTES));
        end
        cnt_reg      <= cnt_next;
        cnt_d_reg    <= cnt_d_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wbuf_we)
        begin
            wbuf_mem[wbuf_waddr] <= wbuf_wdata;
        end
        if (wbuf_re)
        begin
            wbuf_rdata_reg <= wbuf_mem[wbuf_raddr];
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/block_storage_card_registers_top_tb.sv
// self-checking testbench for the block storage card register block: directed and random
// bus requests on valid/ready channels, config over apb, read bytes checked against a predictor
// depends on bscr_pkg, bscr_if and block_storage_card_registers_top
`timescale 1ns / 1ps

module block_storage_card_registers_top_tb;
    import bscr_pkg::*;

    localparam int UNITS        = 2;
    localparam int BLOCK_BYTES  = 512;
    localparam int MAX_BLOCKS   = 64;
    localparam int OFS_W        = $clog2(BLOCK_BYTES);
    localparam int NUM_CFG_REGS = 6;
    localparam int CYCLE_LIMIT  = 800_000;
    localparam int TAIL_CYCLES  = 2 * BLOCK_BYTES + 16;

    localparam logic [PRES_W-1:0]    PRES_EMPTY     = 2'd1;
    localparam logic [PRES_W-1:0]    PRES_CODE3     = 2'd3;
    localparam logic [REG_OFS_W-1:0] OFS_SPARE_LOW  = 4'd5;
    localparam logic [REG_OFS_W-1:0] OFS_SPARE_HIGH = 4'hF;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bscr_req_if req_ch ();
    bscr_rsp_if rsp_ch ();

    block_storage_card_registers_top #(
        .UNITS       (UNITS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_BLOCKS  (MAX_BLOCKS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // card state mirror
    logic [PRES_W-1:0]      cfg_pres   [UNITS];
    logic                   cfg_lock   [UNITS];
    logic [COUNT_W-1:0]     cfg_count  [UNITS];
    int                     active_unit;
    logic [BLOCK_NUM_W-1:0] sel_block  [UNITS];
    logic [OFS_W-1:0]       stream_ofs [UNITS];
    logic                   primed     [UNITS];
    bit   [BYTE_W-1:0]      wbuf       [UNITS * BLOCK_BYTES];
    bit   [BYTE_W-1:0]      medium_img [UNITS * MAX_BLOCKS * BLOCK_BYTES];

    logic [BYTE_W-1:0] expected_bytes [$];
    logic [BYTE_W-1:0] rsp_want;
    int                errors;
    int                request_count;
    int                cycle_count;
    int                rsp_hold;
    bit                gaps_on;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // read byte check and response stalls
    always @(posedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected read_data expected none actual 0x%02h", $time,
                         rsp_ch.read_data);
                errors++;
            end
            else
            begin
                rsp_want = expected_bytes.pop_front();
                if (rsp_ch.read_data !== rsp_want)
                begin
                    $display("%0t: read_data expected 0x%02h actual 0x%02h", $time, rsp_want,
                             rsp_ch.read_data);
                    errors++;
                end
            end
        end
        if (rsp_hold != 0)
        begin
            rsp_hold--;
            rsp_ch.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            rsp_hold = $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    function automatic bit unit_loaded(input int u);
        return cfg_pres[u] == PRES_LOADED;
    endfunction

    function automatic bit block_valid(input int u);
        int n;
        n = (cfg_count[u] > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_count[u]);
        return int'(sel_block[u]) < n;
    endfunction

    function automatic int block_base(input int u);
        return (u * MAX_BLOCKS + int'(sel_block[u])) * BLOCK_BYTES;
    endfunction

    function automatic logic [APB_DW-1:0] register_mirror(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            CFG_PRES0:  return APB_DW'(cfg_pres[0]);
            CFG_PRES1:  return APB_DW'(cfg_pres[1]);
            CFG_PROT0:  return APB_DW'(cfg_lock[0]);
            CFG_PROT1:  return APB_DW'(cfg_lock[1]);
            CFG_COUNT0: return APB_DW'(cfg_count[0]);
            default:    return APB_DW'(cfg_count[1]);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // updates the card mirror for one request and queues the byte it reads back
    task automatic card_access(input logic k, input logic [REG_OFS_W-1:0] ofs,
                               input logic [BYTE_W-1:0] d);
        int u;
        int slot;
        logic [BYTE_W-1:0] rd;
        u    = active_unit;
        slot = u * BLOCK_BYTES;
        rd   = 8'h00;
        if (k == KIND_READ)
        begin
            rd = BYTE_FAIL;
            if (ofs == OFS_STATUS)
            begin
                rd = unit_loaded(u) ? 8'h00 : STATUS_NO_MEDIUM;
                if (cfg_pres[u] == PRES_ABSENT || cfg_lock[u])
                    rd = rd | STATUS_LOCKED;
            end
            else if (ofs == OFS_DATA && unit_loaded(u) && block_valid(u))
            begin
                rd = medium_img[block_base(u) + int'(stream_ofs[u])];
                stream_ofs[u] = stream_ofs[u] + 1'b1;
            end
        end
        else
        begin
            case (ofs)
                OFS_SELECT:
                begin
                    active_unit = d % UNITS;
                    stream_ofs[active_unit] = '0;
                end
                OFS_BLOCK_LO, OFS_BLOCK_HI:
                begin
                    if (ofs == OFS_BLOCK_LO)
                        sel_block[u][BYTE_W-1:0] = d;
                    else
                        sel_block[u][BLOCK_NUM_W-1:BYTE_W] = d;
                    stream_ofs[u] = '0;
                    primed[u]     = 1'b0;
                end
                OFS_DATA:
                begin
                    if (unit_loaded(u) && !cfg_lock[u])
                    begin
                        // fill from the medium, zeros for a failed block
                        if (stream_ofs[u] == 0 && !primed[u])
                        begin
                            for (int i = 0; i < BLOCK_BYTES; i++)
                                wbuf[slot + i] = block_valid(u) ? medium_img[block_base(u) + i]
                                                                : 8'h00;
                            primed[u] = 1'b1;
                        end
                        wbuf[slot + int'(stream_ofs[u])] = d;
                        stream_ofs[u] = stream_ofs[u] + 1'b1;
                        // offset wrapped: commit a valid block
                        if (stream_ofs[u] == 0)
                        begin
                            if (block_valid(u))
                                for (int i = 0; i < BLOCK_BYTES; i++)
                                    medium_img[block_base(u) + i] = wbuf[slot + i];
                            primed[u] = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        expected_bytes.push_back(rd);
    endtask

    task automatic send_request(input logic k, input logic [REG_OFS_W-1:0] ofs,
                                input logic [BYTE_W-1:0] d);
        // staging mid-block without a fill is not allowed; reselect the block instead
        if (k == KIND_WRITE && ofs == OFS_DATA && unit_loaded(active_unit)
                && !cfg_lock[active_unit] && stream_ofs[active_unit] != 0
                && !primed[active_unit])
        begin
            ofs = OFS_BLOCK_LO;
            d   = sel_block[active_unit][BYTE_W-1:0];
        end
        if (!(k == KIND_WRITE && ofs > OFS_DATA))
            request_count++;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.kind       <= k;
        req_ch.reg_offset <= ofs;
        req_ch.write_data <= d;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        card_access(k, ofs, d);
    endtask

    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [CFG_IDX_W-1:0] idx,
                              input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_register(input logic [CFG_IDX_W-1:0] idx);
        logic [APB_DW-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== register_mirror(idx))
        begin
            $display("%0t: config reg %0d expected 0x%0h actual 0x%0h", $time, idx,
                     register_mirror(idx), rd);
            errors++;
        end
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] rd;
        case (idx)
            CFG_PRES0:  cfg_pres[0]  = value[PRES_W-1:0];
            CFG_PRES1:  cfg_pres[1]  = value[PRES_W-1:0];
            CFG_PROT0:  cfg_lock[0]  = value[0];
            CFG_PROT1:  cfg_lock[1]  = value[0];
            CFG_COUNT0: cfg_count[0] = value[COUNT_W-1:0];
            CFG_COUNT1: cfg_count[1] = value[COUNT_W-1:0];
            default:
            begin
            end
        endcase
        apb_access(1'b1, idx, value, rd);
        check_register(idx);
    endtask

    task automatic configure(input logic [PRES_W-1:0] p0, input logic [PRES_W-1:0] p1,
                             input logic l0, input logic l1,
                             input logic [COUNT_W-1:0] c0, input logic [COUNT_W-1:0] c1);
        drain_requests();
        program_register(CFG_PRES0, APB_DW'(p0));
        program_register(CFG_PRES1, APB_DW'(p1));
        program_register(CFG_PROT0, APB_DW'(l0));
        program_register(CFG_PROT1, APB_DW'(l1));
        program_register(CFG_COUNT0, APB_DW'(c0));
        program_register(CFG_COUNT1, APB_DW'(c1));
    endtask

    task automatic test_reset_defaults();
        gaps_on = 1'b0;
        for (int i = 0; i < NUM_CFG_REGS; i++)
            check_register(CFG_IDX_W'(i));
        send_request(KIND_READ, OFS_STATUS, 8'h00);
        send_request(KIND_READ, OFS_DATA, 8'h00);
        send_request(KIND_READ, OFS_SPARE_HIGH, 8'hFF);
        send_request(KIND_WRITE, OFS_DATA, 8'hAA);
        send_request(KIND_WRITE, OFS_SPARE_HIGH, 8'hFF);
        send_request(KIND_WRITE, OFS_SELECT, 8'h01);
        send_request(KIND_READ, OFS_STATUS, 8'h00);
        send_request(KIND_WRITE, OFS_SELECT, 8'h00);
    endtask

    task automatic test_directed_access();
        configure(PRES_LOADED, PRES_EMPTY, 1'b0, 1'b0, COUNT_RESET, 7'd0);
        gaps_on = 1'b1;
        send_request(KIND_WRITE, OFS_BLOCK_LO, 8'h00);
        send_request(KIND_WRITE, OFS_BLOCK_HI, 8'h00);
        send_request(KIND_WRITE, OFS_DATA, 8'hFF);
        send_request(KIND_WRITE, OFS_DATA, 8'h00);
        send_request(KIND_WRITE, OFS_DATA, 8'h5A);
        send_request(KIND_READ, OFS_STATUS, 8'h00);
        send_request(KIND_READ, OFS_SELECT, 8'h00);
        send_request(KIND_READ, OFS_BLOCK_LO, 8'h00);
        // staged bytes stay invisible to reads until commit
        send_request(KIND_WRITE, OFS_SELECT, 8'h00);
        send_request(KIND_READ, OFS_DATA, 8'h00);
        send_request(KIND_READ, OFS_DATA, 8'h00);
        // failed block
        send_request(KIND_WRITE, OFS_BLOCK_HI, 8'hFF);
        send_request(KIND_READ, OFS_DATA, 8'h00);
        send_request(KIND_WRITE, OFS_DATA, 8'h11);
        send_request(KIND_WRITE, OFS_BLOCK_HI, 8'h00);
        // unit 1 has no medium
        send_request(KIND_WRITE, OFS_SELECT, 8'hFF);
        send_request(KIND_READ, OFS_STATUS, 8'h00);
        send_request(KIND_READ, OFS_DATA, 8'h00);
        send_request(KIND_WRITE, OFS_DATA, 8'h22);
        send_request(KIND_READ, OFS_SPARE_LOW, 8'h00);
        send_request(KIND_WRITE, OFS_SELECT, 8'h02);
    endtask

    task automatic test_block_commit();
        configure(PRES_LOADED, PRES_LOADED, 1'b0, 1'b0, COUNT_RESET, COUNT_RESET);
        gaps_on = 1'b1;
        send_request(KIND_WRITE, OFS_SELECT, 8'h01);
        send_request(KIND_WRITE, OFS_BLOCK_LO, 8'(MAX_BLOCKS - 1));
        send_request(KIND_WRITE, OFS_BLOCK_HI, 8'h00);
        repeat (BLOCK_BYTES)
            send_request(KIND_WRITE, OFS_DATA, random_byte());
        send_request(KIND_WRITE, OFS_SELECT, 8'h01);
        repeat (8)
            send_request(KIND_READ, OFS_DATA, 8'h00);
        send_request(KIND_WRITE, OFS_BLOCK_LO, 8'(MAX_BLOCKS));
        send_request(KIND_READ, OFS_DATA, 8'h00);
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_gaps);
        int start;
        int pick;
        int len;
        logic [BYTE_W-1:0] blk_lo;
        logic [BYTE_W-1:0] blk_hi;
        start = request_count;
        while (request_count - start < n_items)
        begin
            gaps_on = with_gaps && ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            len     = $urandom_range(1, 12);
            if (pick < 70)
            begin
                case ($urandom_range(0, 5))
                    0:       blk_lo = 8'($urandom_range(0, 255));
                    1:       blk_lo = 8'(MAX_BLOCKS - 1);
                    default: blk_lo = 8'($urandom_range(0, 7));
                endcase
                blk_hi = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                send_request(KIND_WRITE, OFS_SELECT, 8'($urandom_range(0, 255)));
                send_request(KIND_WRITE, OFS_BLOCK_LO, blk_lo);
                send_request(KIND_WRITE, OFS_BLOCK_HI, blk_hi);
                repeat (len)
                begin
                    send_request(pick < 40 ? KIND_WRITE : KIND_READ, OFS_DATA, random_byte());
                    if ($urandom_range(0, 15) == 0)
                        send_request(KIND_READ, OFS_STATUS, random_byte());
                end
            end
            else if (pick < 85)
            begin
                repeat (len)
                    send_request(1'($urandom_range(0, 1)), OFS_DATA, random_byte());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_request(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                 random_byte());
            end
        end
    endtask

    task automatic test_config_sweep();
        configure(PRES_LOADED, PRES_LOADED, 1'b0, 1'b0, COUNT_RESET, COUNT_RESET);
        test_random_traffic(6, 1'b1);
        configure(PRES_LOADED, PRES_CODE3, 1'b1, 1'b0, 7'd1, 7'd127);
        test_random_traffic(6, 1'b1);
        configure(PRES_LOADED, PRES_LOADED, 1'b0, 1'b1, 7'd0, 7'd4);
        test_random_traffic(6, 1'b1);
        configure(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        test_random_traffic(6, 1'b1);
        configure(PRES_LOADED, PRES_LOADED, 1'b0, 1'b0, COUNT_RESET, 7'd3);
        test_random_traffic(6, 1'b0);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_READ;
        req_ch.reg_offset = OFS_SELECT;
        req_ch.write_data = '0;
        rsp_ch.ready      = 1'b0;
        errors            = 0;
        request_count     = 0;
        cycle_count       = 0;
        rsp_hold          = 0;
        gaps_on           = 1'b0;
        active_unit       = 0;
        for (int u = 0; u < UNITS; u++)
        begin
            cfg_pres[u]   = PRES_ABSENT;
            cfg_lock[u]   = 1'b0;
            cfg_count[u]  = COUNT_RESET;
            sel_block[u]  = '0;
            stream_ofs[u] = '0;
            primed[u]     = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_access();
        test_block_commit();
        test_config_sweep();

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
